FILE: rtl/core/tpjg_pkg.sv
// ----------------------------------------------------------------------------
// Pose jump gate package
// Shared constants and types for the head-tracker pose jump gate.
// ----------------------------------------------------------------------------
package tpjg_pkg;

  localparam int unsigned ANGLE_W     = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned PRESS_W     = 8;
  localparam int unsigned THRESH_W    = 31;
  localparam int unsigned GAP_W       = 16;
  localparam int unsigned CFG_DATA_W  = 31;
  localparam int unsigned CFG_INDEX_W = 1;

  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam cfg_index_t REG_JUMP_THRESHOLD = 1'b0;
  localparam cfg_index_t REG_REARM_GAP_MS   = 1'b1;

  localparam logic [THRESH_W-1:0] JUMP_THRESHOLD_RST = 31'd327680;
  localparam logic [GAP_W-1:0]    REARM_GAP_MS_RST   = 16'd2000;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef struct packed {
    angle_t yaw;
    angle_t pitch;
    angle_t roll;
  } pose_t;

  typedef enum logic [2:0] {
    VERDICT_SEEDED     = 3'd0,
    VERDICT_SMALL_STEP = 3'd1,
    VERDICT_LARGE_CONT = 3'd2,
    VERDICT_JUMP_HELD  = 3'd3,
    VERDICT_FROZEN     = 3'd4,
    VERDICT_DUPLICATE  = 3'd5,
    VERDICT_NO_POSE    = 3'd6
  } verdict_t;

endpackage

FILE: rtl/core/tracker_pose_jump_gate.sv
// ----------------------------------------------------------------------------
// Tracker pose jump gate
// Publish gate for parsed head-tracker packets with recenter press handling.
// ----------------------------------------------------------------------------
// An accepted transaction passes the input register and then the result
// register; the result register holds it while out_ready is low.
// Throughput: one transaction per cycle unless out_ready stalls the output;
// the decision and all gate state update together from the input register.
// Reset: synchronous, active low; clears all gate state, the held count and
// both configuration registers to their default values.
module tracker_pose_jump_gate (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  tpjg_pkg::cfg_index_t                    cfg_index,
  input  logic [tpjg_pkg::CFG_DATA_W-1:0]         cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [tpjg_pkg::ANGLE_W-1:0]     in_yaw_in,
  input  logic signed [tpjg_pkg::ANGLE_W-1:0]     in_pitch_in,
  input  logic signed [tpjg_pkg::ANGLE_W-1:0]     in_roll_in,
  input  logic                                    in_pose_valid,
  input  logic                                    in_has_trailer,
  input  logic [tpjg_pkg::PRESS_W-1:0]            in_press_count,
  input  logic [tpjg_pkg::TIME_W-1:0]             in_arrival_ms,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_publish,
  output logic signed [tpjg_pkg::ANGLE_W-1:0]     out_yaw_out,
  output logic signed [tpjg_pkg::ANGLE_W-1:0]     out_pitch_out,
  output logic signed [tpjg_pkg::ANGLE_W-1:0]     out_roll_out,
  output logic [2:0]                              out_verdict,
  output logic [tpjg_pkg::COUNT_W-1:0]            out_held_total
);

  localparam int unsigned DIFF_W = tpjg_pkg::ANGLE_W + 1;

  logic [tpjg_pkg::THRESH_W-1:0] jump_threshold_r;
  logic [tpjg_pkg::GAP_W-1:0]    rearm_gap_ms_r;

  logic                           in_vld_r;
  tpjg_pkg::pose_t                in_pose_r;
  logic                           in_pose_valid_r;
  logic                           in_has_trailer_r;
  logic [tpjg_pkg::PRESS_W-1:0]   in_press_count_r;
  logic [tpjg_pkg::TIME_W-1:0]    in_arrival_ms_r;

  tpjg_pkg::pose_t                accepted_pose_r, accepted_pose_nxt;
  tpjg_pkg::pose_t                last_source_pose_r, last_source_pose_nxt;
  logic                           gate_seeded_r, gate_seeded_nxt;
  logic                           jump_pending_r, jump_pending_nxt;
  logic                           last_step_large_r, last_step_large_nxt;
  logic [tpjg_pkg::COUNT_W-1:0]   held_counter_r, held_counter_nxt;
  logic                           press_latched_r, press_latched_nxt;
  logic [tpjg_pkg::PRESS_W-1:0]   last_press_value_r, last_press_value_nxt;
  logic [tpjg_pkg::TIME_W-1:0]    last_publish_ms_r, last_publish_ms_nxt;
  logic                           ever_published_r, ever_published_nxt;

  logic                           out_vld_r;
  logic                           publish_r, publish_nxt;
  tpjg_pkg::pose_t                out_pose_r, out_pose_nxt;
  tpjg_pkg::verdict_t             verdict_r, verdict_nxt;

  logic                           advance;
  logic [tpjg_pkg::TIME_W-1:0]    gap;
  logic                           latched_eff;
  logic                           pressed;
  logic                           repeats;
  logic                           jump_large;
  logic [DIFF_W-1:0]              abs_yaw, abs_pitch, abs_roll;
  logic [DIFF_W-1:0]              thresh_ext;

  function automatic logic [DIFF_W-1:0] abs_diff(input tpjg_pkg::angle_t a,
                                                 input tpjg_pkg::angle_t b);
    logic signed [DIFF_W-1:0] d;
    d = {a[tpjg_pkg::ANGLE_W-1], a} - {b[tpjg_pkg::ANGLE_W-1], b};
    abs_diff = d[DIFF_W-1] ? -d : d;
  endfunction

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = !in_vld_r || advance;

  assign gap         = in_arrival_ms_r - last_publish_ms_r;
  assign latched_eff = press_latched_r &&
                       !(ever_published_r && (gap >= {16'd0, rearm_gap_ms_r}));
  assign pressed     = in_has_trailer_r &&
                       (!latched_eff || (in_press_count_r != last_press_value_r));
  assign repeats     = (in_pose_r == last_source_pose_r);

  assign abs_yaw    = abs_diff(in_pose_r.yaw,   accepted_pose_r.yaw);
  assign abs_pitch  = abs_diff(in_pose_r.pitch, accepted_pose_r.pitch);
  assign abs_roll   = abs_diff(in_pose_r.roll,  accepted_pose_r.roll);
  assign thresh_ext = {2'b00, jump_threshold_r};
  assign jump_large = (abs_yaw > thresh_ext) || (abs_pitch > thresh_ext) ||
                      (abs_roll > thresh_ext);

  always_comb begin
    accepted_pose_nxt    = accepted_pose_r;
    last_source_pose_nxt = last_source_pose_r;
    gate_seeded_nxt      = gate_seeded_r;
    jump_pending_nxt     = jump_pending_r;
    last_step_large_nxt  = last_step_large_r;
    held_counter_nxt     = held_counter_r;
    last_publish_ms_nxt  = last_publish_ms_r;
    ever_published_nxt   = ever_published_r;
    press_latched_nxt    = in_has_trailer_r ? 1'b1 : latched_eff;
    last_press_value_nxt = in_has_trailer_r ? in_press_count_r : last_press_value_r;
    publish_nxt          = 1'b0;
    verdict_nxt          = tpjg_pkg::VERDICT_NO_POSE;

    if (in_pose_valid_r) begin
      if (!repeats) begin
        last_source_pose_nxt = in_pose_r;
      end
      if (pressed || !gate_seeded_r) begin
        gate_seeded_nxt     = 1'b1;
        jump_pending_nxt    = 1'b0;
        last_step_large_nxt = 1'b0;
        accepted_pose_nxt   = in_pose_r;
        publish_nxt         = 1'b1;
        verdict_nxt         = tpjg_pkg::VERDICT_SEEDED;
      end else if (repeats) begin
        if (jump_pending_r) begin
          last_step_large_nxt = 1'b0;
          if (held_counter_r != '1) begin
            held_counter_nxt = held_counter_r + 1'b1;
          end
          verdict_nxt = tpjg_pkg::VERDICT_FROZEN;
        end else begin
          publish_nxt = 1'b1;
          verdict_nxt = tpjg_pkg::VERDICT_DUPLICATE;
        end
      end else if (jump_large && !jump_pending_r && !last_step_large_r) begin
        jump_pending_nxt = 1'b1;
        if (held_counter_r != '1) begin
          held_counter_nxt = held_counter_r + 1'b1;
        end
        verdict_nxt = tpjg_pkg::VERDICT_JUMP_HELD;
      end else begin
        jump_pending_nxt    = 1'b0;
        last_step_large_nxt = jump_large;
        accepted_pose_nxt   = in_pose_r;
        publish_nxt         = 1'b1;
        if (jump_large) begin
          verdict_nxt = tpjg_pkg::VERDICT_LARGE_CONT;
        end else begin
          verdict_nxt = tpjg_pkg::VERDICT_SMALL_STEP;
        end
      end
      if (publish_nxt) begin
        last_publish_ms_nxt = in_arrival_ms_r;
        ever_published_nxt  = 1'b1;
      end
    end

    out_pose_nxt = publish_nxt ? in_pose_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_threshold_r   <= tpjg_pkg::JUMP_THRESHOLD_RST;
      rearm_gap_ms_r     <= tpjg_pkg::REARM_GAP_MS_RST;
      in_vld_r           <= 1'b0;
      out_vld_r          <= 1'b0;
      accepted_pose_r    <= '0;
      last_source_pose_r <= '0;
      gate_seeded_r      <= 1'b0;
      jump_pending_r     <= 1'b0;
      last_step_large_r  <= 1'b0;
      held_counter_r     <= '0;
      press_latched_r    <= 1'b0;
      last_press_value_r <= '0;
      last_publish_ms_r  <= '0;
      ever_published_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tpjg_pkg::REG_JUMP_THRESHOLD: jump_threshold_r <= cfg_wdata;
          tpjg_pkg::REG_REARM_GAP_MS:   rearm_gap_ms_r   <= cfg_wdata[tpjg_pkg::GAP_W-1:0];
          default: ;
        endcase
      end

      if (in_ready) begin
        in_vld_r <= in_valid;
      end

      if (advance) begin
        out_vld_r <= in_vld_r;
      end

      if (advance && in_vld_r) begin
        accepted_pose_r    <= accepted_pose_nxt;
        last_source_pose_r <= last_source_pose_nxt;
        gate_seeded_r      <= gate_seeded_nxt;
        jump_pending_r     <= jump_pending_nxt;
        last_step_large_r  <= last_step_large_nxt;
        held_counter_r     <= held_counter_nxt;
        press_latched_r    <= press_latched_nxt;
        last_press_value_r <= last_press_value_nxt;
        last_publish_ms_r  <= last_publish_ms_nxt;
        ever_published_r   <= ever_published_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_pose_r.yaw    <= in_yaw_in;
      in_pose_r.pitch  <= in_pitch_in;
      in_pose_r.roll   <= in_roll_in;
      in_pose_valid_r  <= in_pose_valid;
      in_has_trailer_r <= in_has_trailer;
      in_press_count_r <= in_press_count;
      in_arrival_ms_r  <= in_arrival_ms;
    end
    if (advance && in_vld_r) begin
      publish_r  <= publish_nxt;
      out_pose_r <= out_pose_nxt;
      verdict_r  <= verdict_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_publish    = publish_r;
  assign out_yaw_out    = out_pose_r.yaw;
  assign out_pitch_out  = out_pose_r.pitch;
  assign out_roll_out   = out_pose_r.roll;
  assign out_verdict    = verdict_r;
  assign out_held_total = held_counter_r;

endmodule
